// ----- src/rmvm_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rmvm_pkg
// Shared widths, constants and types of the running statistics block.
// ---------------------------------------------------------------------------
package rmvm_pkg;

	localparam int SAMPLE_WIDTH = 32;
	localparam int COUNT_WIDTH  = 32;
	localparam int FIELD_WIDTH  = 32;
	localparam int SUM_WIDTH    = 63;
	localparam int DIV_WIDTH    = SUM_WIDTH;
	localparam int ITER_WIDTH   = $clog2(DIV_WIDTH + 1);
	localparam int MUL_ITER_W   = $clog2(SAMPLE_WIDTH + 1);
	localparam int PROD_WIDTH   = 2 * SAMPLE_WIDTH;

	localparam logic [FIELD_WIDTH-1:0] MAX_INIT = 32'h8000_0001;
	localparam logic [FIELD_WIDTH-1:0] MIN_INIT = 32'h7fff_ffff;

	localparam logic OP_INCLUDE = 1'b0;
	localparam logic OP_CLEAR   = 1'b1;

	typedef struct packed {
		logic                  start;
		logic [ITER_WIDTH-1:0] steps;
	} rmvm_div_req_t;

endpackage

// ----- src/rmvm_in_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rmvm_in_if
// Input channel: operation and sample with valid/ready handshake.
// ---------------------------------------------------------------------------
interface rmvm_in_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 operation;
	logic [rmvm_pkg::FIELD_WIDTH-1:0]     sample;

	modport source (output valid, output operation, output sample, input ready);
	modport sink   (input valid, input operation, input sample, output ready);
endinterface

// ----- src/rmvm_out_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rmvm_out_if
// Result channel: mean, variance, extremes and count with valid/ready.
// ---------------------------------------------------------------------------
interface rmvm_out_if;
	logic                             valid;
	logic                             ready;
	logic [rmvm_pkg::FIELD_WIDTH-1:0] mean;
	logic [rmvm_pkg::SUM_WIDTH-1:0]   variance;
	logic [rmvm_pkg::FIELD_WIDTH-1:0] maximum;
	logic [rmvm_pkg::FIELD_WIDTH-1:0] minimum;
	logic [rmvm_pkg::FIELD_WIDTH-1:0] sample_count;

	modport source (output valid, output mean, output variance, output maximum,
		output minimum, output sample_count, input ready);
	modport sink   (input valid, input mean, input variance, input maximum,
		input minimum, input sample_count, output ready);
endinterface

// ----- src/rmvm_divider.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rmvm_divider
// Bit-serial restoring divider, one quotient bit per cycle.
// The dividend is taken MSB first for the requested number of steps.
// ---------------------------------------------------------------------------
module rmvm_divider (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rmvm_pkg::rmvm_div_req_t             req,
	input  logic [rmvm_pkg::DIV_WIDTH-1:0]      dividend,
	input  logic [rmvm_pkg::COUNT_WIDTH-1:0]    divisor,
	output logic [rmvm_pkg::DIV_WIDTH-1:0]      quotient,
	output logic                                done
);

	logic [rmvm_pkg::DIV_WIDTH-1:0]   num_q;
	logic [rmvm_pkg::DIV_WIDTH-1:0]   quo_q;
	logic [rmvm_pkg::COUNT_WIDTH-1:0] rem_q;
	logic [rmvm_pkg::COUNT_WIDTH-1:0] den_q;
	logic [rmvm_pkg::ITER_WIDTH-1:0]  left_q;
	logic                             busy_q;
	logic                             done_q;

	logic [rmvm_pkg::COUNT_WIDTH:0]   trial;
	logic [rmvm_pkg::COUNT_WIDTH:0]   diff;
	logic                             fits;

	assign trial = {rem_q, num_q[rmvm_pkg::DIV_WIDTH-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			left_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				left_q <= req.steps;
			end else if (busy_q) begin
				left_q <= left_q - 1'b1;
				if (left_q == rmvm_pkg::ITER_WIDTH'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			// remainder stays below the divisor, so the low bits hold it
			rem_q <= fits ? diff[rmvm_pkg::COUNT_WIDTH-1:0]
				: trial[rmvm_pkg::COUNT_WIDTH-1:0];
			quo_q <= {quo_q[rmvm_pkg::DIV_WIDTH-2:0], fits};
			num_q <= {num_q[rmvm_pkg::DIV_WIDTH-2:0], 1'b0};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// ----- src/rmvm_multiplier.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rmvm_multiplier
// Bit-serial shift-add multiplier for two unsigned magnitudes,
// one multiplier bit per cycle.
// ---------------------------------------------------------------------------
module rmvm_multiplier (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [rmvm_pkg::SAMPLE_WIDTH-1:0]    multiplicand,
	input  logic [rmvm_pkg::SAMPLE_WIDTH-1:0]    multiplier,
	output logic [rmvm_pkg::PROD_WIDTH-1:0]      product,
	output logic                                 done
);

	logic [rmvm_pkg::SAMPLE_WIDTH-1:0] a_q;
	logic [rmvm_pkg::PROD_WIDTH-1:0]   p_q;
	logic [rmvm_pkg::MUL_ITER_W-1:0]   left_q;
	logic                              busy_q;
	logic                              done_q;

	logic [rmvm_pkg::SAMPLE_WIDTH:0]   partial;

	assign partial = {1'b0, p_q[rmvm_pkg::PROD_WIDTH-1:rmvm_pkg::SAMPLE_WIDTH]}
		+ (p_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			left_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				left_q <= rmvm_pkg::MUL_ITER_W'(rmvm_pkg::SAMPLE_WIDTH);
			end else if (busy_q) begin
				left_q <= left_q - 1'b1;
				if (left_q == rmvm_pkg::MUL_ITER_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= multiplicand;
			p_q <= {{rmvm_pkg::SAMPLE_WIDTH{1'b0}}, multiplier};
		end else if (busy_q) begin
			// add on the low multiplier bit, then shift the pair right
			p_q <= {partial, p_q[rmvm_pkg::SAMPLE_WIDTH-1:1]};
		end
	end

	assign product = p_q;
	assign done    = done_q;

endmodule

// ----- src/running_mean_variance_minmax.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// running_mean_variance_minmax
// Integer Welford running mean, population variance, maximum, minimum and
// count over signed samples, built on a shared bit-serial divider and a
// bit-serial multiplier.
// ---------------------------------------------------------------------------
//  channel   dir   handshake     payload
//  request   in    valid/ready   operation, sample
//  result    out   valid/ready   mean, variance, maximum, minimum, sample_count
//
//  The divider produces one quotient bit per cycle and runs twice for an
//  include (mean step, then variance) and once for a clear; the multiplier
//  takes one bit per cycle between the two divider runs of an include.
//  One item is in work at a time; ready is high only in the idle state.
//  The result register frees the block to take the next item while a result
//  waits; a stalled result holds the next one in its final state.
//  Reset is asynchronous, active low, and takes effect at once.
// ---------------------------------------------------------------------------
module running_mean_variance_minmax (
	input  logic       clk,
	input  logic       arst_n,
	rmvm_in_if.sink    request,
	rmvm_out_if.source result
);

	localparam int SW = rmvm_pkg::SAMPLE_WIDTH;
	localparam int CW = rmvm_pkg::COUNT_WIDTH;
	localparam int FW = rmvm_pkg::FIELD_WIDTH;
	localparam int DW = rmvm_pkg::DIV_WIDTH;

	typedef enum logic [8:0] {
		ST_IDLE     = 9'b000000001,
		ST_MEAN_GO  = 9'b000000010,
		ST_MEAN_RUN = 9'b000000100,
		ST_MUL_GO   = 9'b000001000,
		ST_MUL_RUN  = 9'b000010000,
		ST_VAR_GO   = 9'b000100000,
		ST_VAR_RUN  = 9'b001000000,
		ST_OUT      = 9'b010000000,
		ST_SPARE    = 9'b100000000
	} state_t;

	state_t                         state_q;
	logic [SW-1:0]                  x_q;
	logic [SW-1:0]                  mean_q;
	logic [SW-1:0]                  dmag_q;
	logic                           dneg_q;
	logic [CW-1:0]                  count_q;
	logic [rmvm_pkg::SUM_WIDTH-1:0] sum_q;
	logic [FW-1:0]                  max_q;
	logic [FW-1:0]                  min_q;

	logic                           out_valid_q;
	logic [FW-1:0]                  out_mean_q;
	logic [rmvm_pkg::SUM_WIDTH-1:0] out_var_q;
	logic [FW-1:0]                  out_max_q;
	logic [FW-1:0]                  out_min_q;
	logic [FW-1:0]                  out_count_q;

	logic                           in_xfer;
	logic                           out_free;
	logic [SW-1:0]                  x_new;
	logic [FW-1:0]                  x_ext;
	logic [SW:0]                    dev_old;
	logic [SW:0]                    dev_new;
	logic [SW-1:0]                  emag;
	logic [SW:0]                    step;
	logic [SW:0]                    mean_sum;
	logic [rmvm_pkg::SUM_WIDTH+1:0] sum_total;

	rmvm_pkg::rmvm_div_req_t        div_req;
	logic [DW-1:0]                  div_dividend;
	logic [CW-1:0]                  div_divisor;
	logic [DW-1:0]                  div_quotient;
	logic                           div_done;
	logic                           mul_start;
	logic [rmvm_pkg::PROD_WIDTH-1:0] mul_product;
	logic                           mul_done;

	assign in_xfer  = request.valid && request.ready;
	assign out_free = !out_valid_q || result.ready;
	assign request.ready = (state_q == ST_IDLE);

	assign x_new = request.sample[SW-1:0];
	assign x_ext = FW'($signed(x_new));

	// deviation from the old mean, taken at accept
	assign dev_old = {x_new[SW-1], x_new} - {mean_q[SW-1], mean_q};
	// deviation from the updated mean
	assign dev_new = {x_q[SW-1], x_q} - {mean_q[SW-1], mean_q};
	assign emag    = dev_new[SW] ? SW'(~dev_new + 1'b1) : dev_new[SW-1:0];

	assign step     = dneg_q ? (~{1'b0, div_quotient[SW-1:0]} + 1'b1)
		: {1'b0, div_quotient[SW-1:0]};
	assign mean_sum = {mean_q[SW-1], mean_q} + step;

	assign sum_total = {2'b00, sum_q}
		+ (rmvm_pkg::SUM_WIDTH + 2)'(mul_product);

	always_comb begin
		div_req.start = 1'b0;
		div_req.steps = rmvm_pkg::ITER_WIDTH'(DW);
		div_dividend  = {dmag_q, {(DW - SW){1'b0}}};
		div_divisor   = count_q;
		case (state_q)
			ST_MEAN_GO: begin
				div_req.start = 1'b1;
				div_req.steps = rmvm_pkg::ITER_WIDTH'(SW);
			end
			ST_VAR_GO: begin
				div_req.start = 1'b1;
				div_dividend  = sum_q;
				div_divisor   = (count_q == '0) ? CW'(1) : count_q;
			end
			default: begin
			end
		endcase
	end

	assign mul_start = (state_q == ST_MUL_GO);

	rmvm_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quotient),
		.done     (div_done)
	);

	rmvm_multiplier u_multiplier (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (mul_start),
		.multiplicand (emag),
		.multiplier   (dmag_q),
		.product      (mul_product),
		.done         (mul_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mean_q      <= '0;
			count_q     <= '0;
			sum_q       <= '0;
			max_q       <= rmvm_pkg::MAX_INIT;
			min_q       <= rmvm_pkg::MIN_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (request.operation == rmvm_pkg::OP_CLEAR) begin
							count_q <= '0;
							sum_q   <= '0;
							max_q   <= rmvm_pkg::MAX_INIT;
							min_q   <= rmvm_pkg::MIN_INIT;
							state_q <= ST_VAR_GO;
						end else begin
							if (count_q != '1) begin
								count_q <= count_q + 1'b1;
							end
							if ($signed(x_ext) > $signed(max_q)) begin
								max_q <= x_ext;
							end
							if ($signed(x_ext) < $signed(min_q)) begin
								min_q <= x_ext;
							end
							state_q <= ST_MEAN_GO;
						end
					end
				end
				ST_MEAN_GO: begin
					state_q <= ST_MEAN_RUN;
				end
				ST_MEAN_RUN: begin
					if (div_done) begin
						mean_q  <= mean_sum[SW-1:0];
						state_q <= ST_MUL_GO;
					end
				end
				ST_MUL_GO: begin
					state_q <= ST_MUL_RUN;
				end
				ST_MUL_RUN: begin
					if (mul_done) begin
						// saturate the deviation sum at its top value
						sum_q   <= (sum_total[rmvm_pkg::SUM_WIDTH+1:rmvm_pkg::SUM_WIDTH]
							!= 2'b00) ? '1 : sum_total[rmvm_pkg::SUM_WIDTH-1:0];
						state_q <= ST_VAR_GO;
					end
				end
				ST_VAR_GO: begin
					state_q <= ST_VAR_RUN;
				end
				ST_VAR_RUN: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_xfer) begin
			x_q    <= x_new;
			dneg_q <= dev_old[SW];
			dmag_q <= dev_old[SW] ? SW'(~dev_old + 1'b1) : dev_old[SW-1:0];
		end
		if (state_q == ST_OUT && out_free) begin
			out_mean_q  <= FW'($signed(mean_q));
			out_var_q   <= div_quotient;
			out_max_q   <= max_q;
			out_min_q   <= min_q;
			out_count_q <= FW'(count_q);
		end
	end

	assign result.valid        = out_valid_q;
	assign result.mean         = out_mean_q;
	assign result.variance     = out_var_q;
	assign result.maximum      = out_max_q;
	assign result.minimum      = out_min_q;
	assign result.sample_count = out_count_q;

endmodule

// ----- tb/rmvm_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rmvm_checker
// Watches the request and result channels of the running statistics block.
// Keeps its own copy of mean, deviation sum, extremes and count, predicts
// the result of every accepted request and compares each result transfer
// field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module rmvm_checker (
	input  logic clk,
	input  logic arst_n,
	rmvm_in_if   request,
	rmvm_out_if  result,
	output int   mismatches,
	output int   pending
);

	typedef struct packed {
		logic [rmvm_pkg::FIELD_WIDTH-1:0] mean;
		logic [rmvm_pkg::SUM_WIDTH-1:0]   variance;
		logic [rmvm_pkg::FIELD_WIDTH-1:0] maximum;
		logic [rmvm_pkg::FIELD_WIDTH-1:0] minimum;
		logic [rmvm_pkg::FIELD_WIDTH-1:0] sample_count;
	} stats_t;

	localparam logic [63:0] SUM_CEILING = 64'h7fff_ffff_ffff_ffff;

	logic signed [rmvm_pkg::FIELD_WIDTH-1:0] mean_q;
	logic [63:0]                             dev_sum;
	logic signed [rmvm_pkg::FIELD_WIDTH-1:0] largest_q;
	logic signed [rmvm_pkg::FIELD_WIDTH-1:0] smallest_q;
	logic [rmvm_pkg::COUNT_WIDTH-1:0]        count_q;
	stats_t                                  stats_due[$];

	// Apply one request to the shadow state and return the statistics after it.
	function automatic stats_t update_stats(logic op,
		logic [rmvm_pkg::FIELD_WIDTH-1:0] raw);
		logic signed [63:0] x;
		logic signed [63:0] old_mean;
		logic signed [63:0] new_mean;
		logic signed [63:0] d_new;
		logic signed [63:0] d_old;
		logic [63:0]        mag_new;
		logic [63:0]        mag_old;
		logic [63:0]        term;
		logic [63:0]        divisor;
		stats_t             r;
		if (op == rmvm_pkg::OP_CLEAR) begin
			largest_q  = rmvm_pkg::MAX_INIT;
			smallest_q = rmvm_pkg::MIN_INIT;
			dev_sum    = '0;
			count_q    = '0;
		end else begin
			x        = $signed(raw[rmvm_pkg::SAMPLE_WIDTH-1:0]);
			old_mean = mean_q;
			if (count_q != '1)
				count_q = count_q + 1'b1;
			// signed division truncates toward zero
			new_mean = old_mean + (x - old_mean) / $signed(64'(count_q));
			mean_q   = new_mean[rmvm_pkg::FIELD_WIDTH-1:0];
			d_new    = x - new_mean;
			d_old    = x - old_mean;
			mag_new  = (d_new < 0) ? -d_new : d_new;
			mag_old  = (d_old < 0) ? -d_old : d_old;
			term     = mag_new * mag_old;
			if (term > SUM_CEILING - dev_sum)
				dev_sum = SUM_CEILING;
			else
				dev_sum = dev_sum + term;
			if (x > largest_q)
				largest_q = x[rmvm_pkg::FIELD_WIDTH-1:0];
			if (x < smallest_q)
				smallest_q = x[rmvm_pkg::FIELD_WIDTH-1:0];
		end
		divisor        = (count_q == '0) ? 64'd1 : 64'(count_q);
		r.mean         = mean_q;
		r.variance     = rmvm_pkg::SUM_WIDTH'(dev_sum / divisor);
		r.maximum      = largest_q;
		r.minimum      = smallest_q;
		r.sample_count = rmvm_pkg::FIELD_WIDTH'(count_q);
		return r;
	endfunction

	task automatic flag(input string field, input logic [63:0] want, input logic [63:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on %s at %0t: expected %h, got %h", field, $realtime, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		stats_t want;
		if (!arst_n) begin
			mean_q     = '0;
			dev_sum    = '0;
			largest_q  = rmvm_pkg::MAX_INIT;
			smallest_q = rmvm_pkg::MIN_INIT;
			count_q    = '0;
			stats_due.delete();
			mismatches = 0;
			pending    = 0;
		end else begin
			if (request.valid && request.ready)
				stats_due.push_back(update_stats(request.operation, request.sample));
			if (result.valid && result.ready) begin
				if (stats_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result transfer at %0t", $realtime);
				end else begin
					want = stats_due.pop_front();
					if (result.mean !== want.mean)
						flag("mean", want.mean, result.mean);
					if (result.variance !== want.variance)
						flag("variance", want.variance, result.variance);
					if (result.maximum !== want.maximum)
						flag("maximum", want.maximum, result.maximum);
					if (result.minimum !== want.minimum)
						flag("minimum", want.minimum, result.minimum);
					if (result.sample_count !== want.sample_count)
						flag("sample_count", want.sample_count, result.sample_count);
				end
			end
			pending = stats_due.size();
		end
	end

endmodule

// ----- tb/running_mean_variance_minmax_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// running_mean_variance_minmax_test
// Drives the running statistics block with directed extremes, clears and
// sum saturation, then random sample streams under several idle and stall
// mixes, including one long result hold-off that backs up the request side.
// ---------------------------------------------------------------------------
module running_mean_variance_minmax_test;

	localparam int QUIET_LIMIT   = 5000;
	localparam int LONG_HOLD     = 600;
	localparam int DRAIN_CYCLES  = 300;
	localparam int PHASE_ITEMS   = 150;

	logic clk;
	logic arst_n;
	int   idle_pct;
	int   stall_pct;
	int   mismatches;
	int   pending;
	int   quiet_cycles;
	int   results_seen;

	rmvm_in_if  request ();
	rmvm_out_if result ();

	running_mean_variance_minmax uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.result  (result)
	);

	rmvm_checker stats_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.request    (request),
		.result     (result),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic send(input logic op, input logic [rmvm_pkg::FIELD_WIDTH-1:0] value);
		while ($urandom_range(99) < idle_pct) begin
			request.valid <= 1'b0;
			@(posedge clk);
		end
		request.valid     <= 1'b1;
		request.operation <= op;
		request.sample    <= value;
		do @(posedge clk); while (!request.ready);
	endtask

	// Mix of extremes, full-range values and values clustered around a level.
	function automatic logic [rmvm_pkg::FIELD_WIDTH-1:0] pick_sample(
		logic signed [rmvm_pkg::FIELD_WIDTH-1:0] level);
		logic signed [rmvm_pkg::FIELD_WIDTH-1:0] v;
		case ($urandom_range(9))
			0: case ($urandom_range(3))
				0: v = 32'h7fff_ffff;
				1: v = 32'h8000_0000;
				2: v = '0;
				default: v = '1;
			endcase
			1, 2: v = $urandom;
			default: v = level + $signed(32'($urandom_range(2000))) - 32'sd1000;
		endcase
		return v;
	endfunction

	// result side: random stalls, plus one long hold-off while requests keep coming
	initial begin : result_side
		int  hold_left;
		bit  held;
		hold_left    = 0;
		held         = 1'b0;
		result.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (!held && results_seen >= 50) begin
				held      = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				result.ready <= 1'b0;
			end else
				result.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((request.valid && request.ready) || (result.valid && result.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (result.valid && result.ready)
			results_seen++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		int                                      idle_mix[4];
		int                                      stall_mix[4];
		logic signed [rmvm_pkg::FIELD_WIDTH-1:0] level;
		idle_mix          = '{0, 46, 0, 12};
		stall_mix         = '{0, 0, 46, 12};
		quiet_cycles      = 0;
		results_seen      = 0;
		idle_pct          = 0;
		stall_pct         = 0;
		arst_n            = 1'b0;
		request.valid     = 1'b0;
		request.operation = rmvm_pkg::OP_INCLUDE;
		request.sample    = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// clear straight after reset, then most negative sample alone
		send(rmvm_pkg::OP_CLEAR, '0);
		send(rmvm_pkg::OP_INCLUDE, 32'h8000_0000);
		// alternate extremes to drive the deviation sum into saturation
		send(rmvm_pkg::OP_INCLUDE, 32'h7fff_ffff);
		send(rmvm_pkg::OP_INCLUDE, 32'h8000_0000);
		send(rmvm_pkg::OP_INCLUDE, 32'h7fff_ffff);
		send(rmvm_pkg::OP_INCLUDE, 32'h8000_0000);
		send(rmvm_pkg::OP_INCLUDE, 32'h7fff_ffff);
		// clear keeps the mean; sample field is ignored
		send(rmvm_pkg::OP_CLEAR, 32'hffff_ffff);
		send(rmvm_pkg::OP_CLEAR, 32'h1234_5678);
		send(rmvm_pkg::OP_INCLUDE, '0);
		send(rmvm_pkg::OP_INCLUDE, 32'hffff_ffff);
		send(rmvm_pkg::OP_INCLUDE, 32'h0000_0001);
		send(rmvm_pkg::OP_INCLUDE, 32'h5555_5555);
		send(rmvm_pkg::OP_INCLUDE, 32'haaaa_aaaa);
		send(rmvm_pkg::OP_CLEAR, '0);
		send(rmvm_pkg::OP_INCLUDE, 32'h7fff_ffff);
		send(rmvm_pkg::OP_CLEAR, '1);
		send(rmvm_pkg::OP_INCLUDE, 32'h8000_0000);
		send(rmvm_pkg::OP_INCLUDE, -32'sd3);
		send(rmvm_pkg::OP_INCLUDE, -32'sd7);
		send(rmvm_pkg::OP_INCLUDE, 32'sd10);

		level = $urandom;
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct  = idle_mix[ph];
			stall_pct = stall_mix[ph];
			repeat (PHASE_ITEMS) begin
				if ($urandom_range(29) == 0) begin
					send(rmvm_pkg::OP_CLEAR, $urandom);
					// move the cluster after a clear, now and then to an edge
					level = ($urandom_range(3) == 0) ? 32'h7fff_fc00 : $urandom;
				end else
					send(rmvm_pkg::OP_INCLUDE, pick_sample(level));
			end
		end
		request.valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
